// ----- rtl/mpfb_pkg.sv -----
package mpfb_pkg;

  typedef enum logic [2:0] {
    OP_SET     = 3'd0,
    OP_INVERT  = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_PRESENT = 3'd3,
    OP_READ    = 3'd4
  } op_e;

  localparam int unsigned CoordW = 8;
  localparam int unsigned PageW  = 3;

  // classified command passed from front to back
  typedef struct packed {
    logic             reject;
    logic [2:0]       op;
    logic [CoordW:0]  x0;
    logic [CoordW:0]  x1;    // exclusive end column
    logic [CoordW:0]  y0;
    logic [CoordW:0]  y1;    // exclusive end row
    logic [PageW:0]   page;
  } cmd_t;

endpackage

// ----- rtl/mpfb_ram.sv -----
module mpfb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/mpfb_front.sv -----
module mpfb_front #(
  parameter int unsigned ScreenWidth  = 128,
  parameter int unsigned ScreenHeight = 64,
  parameter int unsigned PageCount    = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [2:0]        op_i,
  input  logic [7:0]        pos_x_i,
  input  logic [7:0]        pos_y_i,
  input  logic [7:0]        rect_width_i,
  input  logic [7:0]        rect_height_i,
  input  logic [2:0]        read_page_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output mpfb_pkg::cmd_t    cmd_o
);

  localparam int unsigned Depth = 2;

  mpfb_pkg::cmd_t cmd_d;
  mpfb_pkg::cmd_t fifo_q [Depth];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  logic [8:0]     xe, ye, ymax;
  logic           row_ok, push, pop;

  // rows on pages beyond PageCount are never touched
  assign ymax = (ScreenHeight < PageCount * 8) ? 9'(ScreenHeight) : 9'(PageCount * 8);
  assign row_ok = {1'b0, pos_y_i} < ymax;

  always_comb begin
    xe = {1'b0, pos_x_i} + {1'b0, rect_width_i};
    ye = {1'b0, pos_y_i} + {1'b0, rect_height_i};
    if (xe > 9'(ScreenWidth)) xe = 9'(ScreenWidth);
    if (ye > ymax) ye = ymax;
    cmd_d.op   = op_i;
    cmd_d.x0   = {1'b0, pos_x_i};
    cmd_d.x1   = xe;
    cmd_d.y0   = {1'b0, pos_y_i};
    cmd_d.y1   = ye;
    cmd_d.page = {1'b0, read_page_i};
    unique case (op_i)
      mpfb_pkg::OP_SET:
        cmd_d.reject = !({1'b0, pos_x_i} < 9'(ScreenWidth) && row_ok);
      mpfb_pkg::OP_INVERT:
        cmd_d.reject = !({1'b0, pos_x_i} < 9'(ScreenWidth) &&
                         {1'b0, pos_y_i} < 9'(ScreenHeight));
      mpfb_pkg::OP_CLEAR, mpfb_pkg::OP_PRESENT: cmd_d.reject = 1'b0;
      mpfb_pkg::OP_READ:
        cmd_d.reject = !({1'b0, pos_x_i} < 9'(ScreenWidth) &&
                         {2'b00, read_page_i} < 5'(PageCount));
      default: cmd_d.reject = 1'b1;
    endcase
  end

  assign ready_o     = cnt_q != 2'(Depth);
  assign push        = valid_i && ready_o;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= cmd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- rtl/mpfb_back.sv -----
module mpfb_back #(
  parameter int unsigned ScreenWidth  = 128,
  parameter int unsigned ScreenHeight = 64,
  parameter int unsigned PageCount    = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  mpfb_pkg::cmd_t    cmd_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic [7:0]        read_data_o,
  output logic              status_o,
  output logic              busy_o
);

  localparam int unsigned Bytes = ScreenWidth * PageCount;
  localparam int unsigned AW    = $clog2(Bytes);

  typedef enum logic [2:0] {
    S_IDLE, S_WIPE, S_RD, S_SHOW, S_WAIT, S_WR, S_RES, S_SWEEP
  } state_e;

  state_e          state_q;
  mpfb_pkg::cmd_t  cmd_q;
  logic [AW:0]     sweep_q;
  logic [8:0]      col_q, row_q;
  logic            res_valid_q, status_q;
  logic [7:0]      rdata_q;
  logic            rst_wipe_q;

  logic            d_we, s_we;
  logic [AW-1:0]   d_waddr, d_raddr, s_waddr, s_raddr;
  logic [7:0]      d_wdata, d_rdata, s_rdata, s_wdata;
  logic [AW-1:0]   pix_addr;
  logic [7:0]      pix_mask, row_mask;
  logic [8:0]      row_end;

  assign pix_addr = AW'(32'(row_q[8:3]) * ScreenWidth + 32'(col_q));
  assign pix_mask = 8'h01 << row_q[2:0];
  // rows of the current page inside [row_q, row_end)
  assign row_end  = (cmd_q.y1 < {row_q[8:3] + 6'd1, 3'b000}) ? cmd_q.y1
                                                            : {row_q[8:3] + 6'd1, 3'b000};
  always_comb begin
    row_mask = '0;
    for (int b = 0; b < 8; b++) begin
      if (9'(b) >= {6'd0, row_q[2:0]} && {row_q[8:3], 3'(b)} < row_end) row_mask[b] = 1'b1;
    end
  end

  always_comb begin
    d_we    = 1'b0;
    d_waddr = pix_addr;
    d_wdata = d_rdata;
    d_raddr = pix_addr;
    s_we    = 1'b0;
    s_waddr = sweep_q[AW-1:0];
    s_raddr = AW'(32'(cmd_q.page) * ScreenWidth + 32'(cmd_q.x0));
    if (state_q == S_WIPE || rst_wipe_q) begin
      d_we = 1'b1; d_waddr = sweep_q[AW-1:0]; d_wdata = '0;
      s_we = rst_wipe_q;
    end else if (state_q == S_SWEEP) begin
      d_raddr = sweep_q[AW-1:0];
    end else if (state_q == S_WR) begin
      d_we = 1'b1;
      d_wdata = (cmd_q.op == mpfb_pkg::OP_SET) ? (d_rdata | pix_mask) : (d_rdata ^ row_mask);
    end
    if (state_q == S_SWEEP && sweep_q != '0) begin
      s_we = 1'b1; s_waddr = AW'(sweep_q - 1'b1);
    end
  end

  assign s_wdata = rst_wipe_q ? 8'h00 : d_rdata;

  mpfb_ram #(.Width(8), .Depth(Bytes)) u_draw (
    .clk_i, .we_i(d_we), .waddr_i(d_waddr), .wdata_i(d_wdata),
    .raddr_i(d_raddr), .rdata_o(d_rdata)
  );
  mpfb_ram #(.Width(8), .Depth(Bytes)) u_shown (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  assign cmd_ready_o = state_q == S_IDLE && !rst_wipe_q && !res_valid_q;
  assign res_valid_o = res_valid_q;
  assign read_data_o = rdata_q;
  assign status_o    = status_q;
  assign busy_o      = rst_wipe_q;

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i && cmd_ready_o) cmd_q <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sweep_q     <= '0;
      col_q       <= '0;
      row_q       <= '0;
      res_valid_q <= 1'b0;
      status_q    <= 1'b0;
      rdata_q     <= '0;
      rst_wipe_q  <= 1'b1;
    end else begin
      if (res_valid_q && res_ready_i) res_valid_q <= 1'b0;
      if (rst_wipe_q) begin
        // clear both buffers once after reset
        sweep_q <= sweep_q + 1'b1;
        if (sweep_q == (AW+1)'(Bytes - 1)) begin
          rst_wipe_q <= 1'b0;
          sweep_q    <= '0;
        end
      end else begin
        unique case (state_q)
          S_IDLE: if (cmd_valid_i && cmd_ready_o) begin
            status_q <= cmd_i.reject;
            rdata_q  <= '0;
            col_q    <= cmd_i.x0;
            row_q    <= cmd_i.y0;
            sweep_q  <= '0;
            if (cmd_i.reject) state_q <= S_RES;
            else begin
              unique case (cmd_i.op)
                mpfb_pkg::OP_SET:     state_q <= S_RD;
                mpfb_pkg::OP_INVERT:
                  state_q <= (cmd_i.x1 > cmd_i.x0 && cmd_i.y1 > cmd_i.y0) ? S_RD : S_RES;
                mpfb_pkg::OP_CLEAR:   state_q <= S_WIPE;
                mpfb_pkg::OP_PRESENT: state_q <= S_SWEEP;
                default:              state_q <= S_SHOW;
              endcase
            end
          end
          S_WIPE: begin
            sweep_q <= sweep_q + 1'b1;
            if (sweep_q == (AW+1)'(Bytes - 1)) state_q <= S_RES;
          end
          S_SWEEP: begin
            sweep_q <= sweep_q + 1'b1;
            if (sweep_q == (AW+1)'(Bytes)) state_q <= S_RES;
          end
          S_RD: state_q <= S_WR;
          // present the shown-buffer address in S_SHOW, then take the registered RAM data in S_WAIT
          S_SHOW: state_q <= S_WAIT;
          S_WAIT: begin
            rdata_q <= s_rdata;
            state_q <= S_RES;
          end
          S_WR: begin
            if (cmd_q.op == mpfb_pkg::OP_SET) state_q <= S_RES;
            else if (col_q + 9'd1 < cmd_q.x1) begin
              col_q   <= col_q + 9'd1;
              state_q <= S_RD;
            end else if (row_end < cmd_q.y1) begin
              col_q   <= cmd_q.x0;
              row_q   <= row_end;
              state_q <= S_RD;
            end else state_q <= S_RES;
          end
          S_RES: begin
            res_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

endmodule

// ----- rtl/mono_page_framebuffer_engine_core.sv -----
// channel  dir  tdata fields (low bit up)                              tuser
// s_axis   in   op[2:0] pos_x[10:3] pos_y[18:11] rect_width[26:19]     -
//               rect_height[34:27] read_page[37:35]
// m_axis   out  read_data[7:0] status[8]                               -
// Set pixel reads then writes its byte; read addresses the shown buffer, then
// takes its data; invert reads and writes each byte touched, one byte per page row per
// column; clear and present sweep every buffer byte (SCREEN_WIDTH*PAGE_COUNT), bound by the RAM port.
// After reset both buffers are cleared, all SCREEN_WIDTH*PAGE_COUNT bytes.
// A two-entry command queue takes requests while the back end works or stalls.
module mono_page_framebuffer_engine_core #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 64,
  parameter int unsigned PAGE_COUNT    = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // op, pos_x, pos_y, rect_width, rect_height, read_page
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // read_data, status
);

  mpfb_pkg::cmd_t cmd;
  logic           cmd_valid, cmd_ready, busy, status;
  logic [7:0]     read_data;

  mpfb_front #(.ScreenWidth(SCREEN_WIDTH), .ScreenHeight(SCREEN_HEIGHT),
               .PageCount(PAGE_COUNT)) u_front (
    .clk_i, .rst_ni,
    .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .op_i(s_axis_tdata[2:0]), .pos_x_i(s_axis_tdata[10:3]),
    .pos_y_i(s_axis_tdata[18:11]), .rect_width_i(s_axis_tdata[26:19]),
    .rect_height_i(s_axis_tdata[34:27]), .read_page_i(s_axis_tdata[37:35]),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  mpfb_back #(.ScreenWidth(SCREEN_WIDTH), .ScreenHeight(SCREEN_HEIGHT),
              .PageCount(PAGE_COUNT)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .read_data_o(read_data), .status_o(status), .busy_o(busy)
  );

  assign m_axis_tdata = {7'd0, status, read_data};

  // nothing taken from the queue during the power-up wipe
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |-> !cmd_ready)
    else $error("command taken during wipe");
  // a rejected request never returns data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && status |-> read_data == 8'h00)
    else $error("rejected request returned data");
  // no result is raised straight out of the power-up wipe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!busy))
    else $error("result during wipe");

endmodule
